// File: hdl/cpv_pkg.sv
package cpv_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 24;
  localparam int unsigned FIFO_AW = 2;
  localparam int unsigned FIFO_DEPTH = 1 << FIFO_AW;

  typedef struct packed {
    logic hit;
    logic coin;
    logic sx;
    logic sy;
  } cpv_flags_t;

  localparam int unsigned FLAGS_W = $bits(cpv_flags_t);

endpackage

// File: hdl/circle_penetration_vector_top.sv
// Circle-circle penetration vector, streaming, one pair per cycle.
// Throughput: one transfer per cycle in and out while the output is taken.
// Each pair passes 2*COORD_WIDTH+8 registers, the first loaded at the input transfer
// (3 front, queue, COORD_WIDTH+1 square-root, scale, COORD_WIDTH+1 divide, output).
// A 4-entry queue sits between the classify front and the sqrt/divide back.
// Reset clears all valid bits and queue pointers; payload is not reset.
module circle_penetration_vector_top #(
  parameter int unsigned COORD_WIDTH = cpv_pkg::COORD_WIDTH_DEF,
  localparam int unsigned IN_W  = ((6*COORD_WIDTH - 2 + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((2*COORD_WIDTH + 2 + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // ax, ay, bx, by, radius_a, radius_b
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // push_x, push_y
  output logic [OUT_W-1:0] m_axis_tdata,
  // overlap, coincident
  output logic [1:0]       m_axis_tuser
);
  import cpv_pkg::*;

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned DW = 5*W + FLAGS_W;

  logic           f_valid, f_ready;
  logic [2*W-1:0] f_dist2, b_dist2;
  logic [W-1:0]   f_mx, f_my, f_sum, b_mx, b_my, b_sum;
  cpv_flags_t     f_flags, b_flags;
  logic [DW-1:0]  q_in, q_out;
  logic           q_full, q_empty, q_pop, b_ready;
  logic [W:0]     push_x, push_y;
  logic           overlap, coincident;

  cpv_front #(.W(W)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s_axis_tvalid),
    .ready_o    (s_axis_tready),
    .ax_i       (s_axis_tdata[W-1:0]),
    .ay_i       (s_axis_tdata[2*W-1:W]),
    .bx_i       (s_axis_tdata[3*W-1:2*W]),
    .by_i       (s_axis_tdata[4*W-1:3*W]),
    .radius_a_i (s_axis_tdata[5*W-2:4*W]),
    .radius_b_i (s_axis_tdata[6*W-3:5*W-1]),
    .valid_o    (f_valid),
    .ready_i    (f_ready),
    .dist2_o    (f_dist2),
    .mx_o       (f_mx),
    .my_o       (f_my),
    .sum_o      (f_sum),
    .flags_o    (f_flags)
  );

  assign f_ready = ~q_full;
  assign q_in    = {f_dist2, f_mx, f_my, f_sum, f_flags};
  assign q_pop   = b_ready & ~q_empty;

  cpv_fifo #(.DW(DW)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid & ~q_full),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .empty_o (q_empty)
  );

  assign {b_dist2, b_mx, b_my, b_sum, b_flags} = q_out;

  cpv_back #(.W(W)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (~q_empty),
    .ready_o      (b_ready),
    .dist2_i      (b_dist2),
    .mx_i         (b_mx),
    .my_i         (b_my),
    .sum_i        (b_sum),
    .flags_i      (b_flags),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .push_x_o     (push_x),
    .push_y_o     (push_y),
    .overlap_o    (overlap),
    .coincident_o (coincident)
  );

  assign m_axis_tdata = OUT_W'({push_y, push_x});
  assign m_axis_tuser = {coincident, overlap};

endmodule

// File: hdl/cpv_front.sv
module cpv_front #(
  parameter int unsigned W = cpv_pkg::COORD_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [W-1:0]        ax_i,
  input  logic [W-1:0]        ay_i,
  input  logic [W-1:0]        bx_i,
  input  logic [W-1:0]        by_i,
  input  logic [W-2:0]        radius_a_i,
  input  logic [W-2:0]        radius_b_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [2*W-1:0]      dist2_o,
  output logic [W-1:0]        mx_o,
  output logic [W-1:0]        my_o,
  output logic [W-1:0]        sum_o,
  output cpv_pkg::cpv_flags_t flags_o
);
  import cpv_pkg::*;

  logic adv;
  logic v1_q, v2_q, v3_q;

  logic [W:0]   dx, dy;
  logic [W:0]   mx1_q, my1_q, mx2_q, my2_q;
  logic         sx1_q, sy1_q, sx2_q, sy2_q;
  logic [W-1:0] sum1_q, sum2v_q;
  logic [2*W+1:0] x2_full, y2_full;
  logic [2*W:0]   x2_q, y2_q;
  logic [2*W-1:0] sq_q;
  logic [2*W+1:0] dist2;
  logic           hit;

  logic [2*W-1:0] dist2_q;
  logic [W-1:0]   mx3_q, my3_q, sum3_q;
  cpv_flags_t     flags_q;

  assign adv     = ~v3_q | ready_i;
  assign ready_o = adv;
  assign valid_o = v3_q;

  assign dx = {ax_i[W-1], ax_i} - {bx_i[W-1], bx_i};
  assign dy = {ay_i[W-1], ay_i} - {by_i[W-1], by_i};

  assign x2_full = mx1_q * mx1_q;
  assign y2_full = my1_q * my1_q;

  assign dist2 = {1'b0, x2_q} + {1'b0, y2_q};
  assign hit   = dist2 < {2'b00, sq_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sx1_q  <= dx[W];
      sy1_q  <= dy[W];
      mx1_q  <= dx[W] ? (~dx + 1'b1) : dx;
      my1_q  <= dy[W] ? (~dy + 1'b1) : dy;
      sum1_q <= {1'b0, radius_a_i} + {1'b0, radius_b_i};

      x2_q    <= x2_full[2*W:0];
      y2_q    <= y2_full[2*W:0];
      sq_q    <= sum1_q * sum1_q;
      mx2_q   <= mx1_q;
      my2_q   <= my1_q;
      sx2_q   <= sx1_q;
      sy2_q   <= sy1_q;
      sum2v_q <= sum1_q;

      dist2_q      <= dist2[2*W-1:0];
      mx3_q        <= mx2_q[W-1:0];
      my3_q        <= my2_q[W-1:0];
      sum3_q       <= sum2v_q;
      flags_q.hit  <= hit;
      flags_q.coin <= hit & (dist2 == '0);
      flags_q.sx   <= sx2_q;
      flags_q.sy   <= sy2_q;
    end
  end

  assign dist2_o = dist2_q;
  assign mx_o    = mx3_q;
  assign my_o    = my3_q;
  assign sum_o   = sum3_q;
  assign flags_o = flags_q;

endmodule

// File: hdl/cpv_fifo.sv
module cpv_fifo #(
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic [DW-1:0] data_o,
  output logic          empty_o
);
  import cpv_pkg::*;

  logic [DW-1:0]      mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_AW:0]   cnt_q;

  assign full_o  = (cnt_q == FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

// File: hdl/cpv_back.sv
module cpv_back #(
  parameter int unsigned W = cpv_pkg::COORD_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [2*W-1:0]      dist2_i,
  input  logic [W-1:0]        mx_i,
  input  logic [W-1:0]        my_i,
  input  logic [W-1:0]        sum_i,
  input  cpv_pkg::cpv_flags_t flags_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [W:0]          push_x_o,
  output logic [W:0]          push_y_o,
  output logic                overlap_o,
  output logic                coincident_o
);
  import cpv_pkg::*;

  localparam int unsigned NV = 2*W + 4;

  logic          adv;
  logic [NV-1:0] vld_q;

  // square root stages
  logic [2*W-1:0] rad_q  [W+1];
  logic [W+1:0]   rem_q  [W+1];
  logic [W-1:0]   root_q [W+1];
  logic [W-1:0]   smx_q  [W+1];
  logic [W-1:0]   smy_q  [W+1];
  logic [W-1:0]   ssum_q [W+1];
  cpv_flags_t     sf_q   [W+1];

  // scale stage
  logic [W-1:0]   len;
  logic [2*W-1:0] px_q, py_q;
  logic [W-1:0]   md_q;
  cpv_flags_t     mf_q;

  // divide stages
  logic [W-1:0] rx_q [W+1];
  logic [W-1:0] ry_q [W+1];
  logic [W-1:0] nx_q [W+1];
  logic [W-1:0] ny_q [W+1];
  logic [W-1:0] qx_q [W+1];
  logic [W-1:0] qy_q [W+1];
  logic [W-1:0] dd_q [W+1];
  cpv_flags_t   df_q [W+1];

  logic [W:0] px_o_q, py_o_q;
  logic       ov_q, co_q;
  logic       keep;
  logic [W:0] qx_ext, qy_ext;

  assign adv     = ~vld_q[NV-1] | ready_i;
  assign ready_o = adv;
  assign valid_o = vld_q[NV-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NV-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rad_q[0]  <= dist2_i;
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      smx_q[0]  <= mx_i;
      smy_q[0]  <= my_i;
      ssum_q[0] <= sum_i;
      sf_q[0]   <= flags_i;
    end
  end

  for (genvar k = 1; k <= W; k++) begin : g_sqrt
    logic [W+1:0] t, trial;
    logic         ge;
    always_comb begin
      t     = {rem_q[k-1][W-1:0], rad_q[k-1][2*W-1:2*W-2]};
      trial = {root_q[k-1], 2'b01};
      ge    = (t >= trial);
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        rad_q[k]  <= rad_q[k-1] << 2;
        rem_q[k]  <= ge ? (t - trial) : t;
        root_q[k] <= {root_q[k-1][W-2:0], ge};
        smx_q[k]  <= smx_q[k-1];
        smy_q[k]  <= smy_q[k-1];
        ssum_q[k] <= ssum_q[k-1];
        sf_q[k]   <= sf_q[k-1];
      end
    end
  end

  assign len = ssum_q[W] - root_q[W];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      px_q <= smx_q[W] * len;
      py_q <= smy_q[W] * len;
      md_q <= root_q[W];
      mf_q <= sf_q[W];

      rx_q[0] <= px_q[2*W-1:W];
      ry_q[0] <= py_q[2*W-1:W];
      nx_q[0] <= px_q[W-1:0];
      ny_q[0] <= py_q[W-1:0];
      qx_q[0] <= '0;
      qy_q[0] <= '0;
      dd_q[0] <= md_q;
      df_q[0] <= mf_q;
    end
  end

  for (genvar k = 1; k <= W; k++) begin : g_div
    logic [W:0] tx, ty, dv;
    logic       gx, gy;
    logic [W:0] sx, sy;
    always_comb begin
      tx = {rx_q[k-1], nx_q[k-1][W-1]};
      ty = {ry_q[k-1], ny_q[k-1][W-1]};
      dv = {1'b0, dd_q[k-1]};
      gx = (tx >= dv);
      gy = (ty >= dv);
      sx = gx ? (tx - dv) : tx;
      sy = gy ? (ty - dv) : ty;
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        rx_q[k] <= sx[W-1:0];
        ry_q[k] <= sy[W-1:0];
        nx_q[k] <= nx_q[k-1] << 1;
        ny_q[k] <= ny_q[k-1] << 1;
        qx_q[k] <= {qx_q[k-1][W-2:0], gx};
        qy_q[k] <= {qy_q[k-1][W-2:0], gy};
        dd_q[k] <= dd_q[k-1];
        df_q[k] <= df_q[k-1];
      end
    end
  end

  assign keep   = df_q[W].hit & ~df_q[W].coin;
  assign qx_ext = {1'b0, qx_q[W]};
  assign qy_ext = {1'b0, qy_q[W]};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      px_o_q <= keep ? (df_q[W].sx ? (~qx_ext + 1'b1) : qx_ext) : '0;
      py_o_q <= keep ? (df_q[W].sy ? (~qy_ext + 1'b1) : qy_ext) : '0;
      ov_q   <= df_q[W].hit;
      co_q   <= df_q[W].coin;
    end
  end

  assign push_x_o     = px_o_q;
  assign push_y_o     = py_o_q;
  assign overlap_o    = ov_q;
  assign coincident_o = co_q;

endmodule

// File: dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW    = cpv_pkg::COORD_WIDTH_DEF;
  localparam int unsigned IN_W  = ((6*CW - 2 + 7) / 8) * 8;
  localparam int unsigned OUT_W = ((2*CW + 2 + 7) / 8) * 8;
  localparam int unsigned LATENCY = 2*CW + 8;

  typedef struct {
    logic signed [CW-1:0] ax, ay, bx, by;
    logic [CW-2:0]        ra, rb;
    bit                   drain;
  } pair_t;

  typedef struct {
    logic [CW:0] px, py;
    logic        ov, co;
  } push_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  // ax, ay, bx, by, radius_a, radius_b
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  // push_x, push_y
  logic [OUT_W-1:0] m_axis_tdata;
  // overlap, coincident
  logic [1:0]       m_axis_tuser;

  circle_penetration_vector_top dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  pair_t pair_q[$];
  push_t push_q[$];
  pair_t cur_pair;
  int    errors = 0;
  int    in_count = 0;
  int    gap_in = 0;
  int    gap_out = 0;
  int    hold_cnt = 0;
  bit    hold_done = 1'b0;
  bit    calm_in = 1'b0;
  bit    calm_out = 1'b0;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [CW:0] scale_comp(longint dc, longint unsigned len,
                                             longint unsigned d);
    longint unsigned q;
    q = ((dc < 0 ? -dc : dc) * len) / d;
    return dc < 0 ? (CW+1)'(0) - q[CW:0] : q[CW:0];
  endfunction

  function automatic push_t predict_push(pair_t p);
    push_t r;
    longint dx, dy;
    longint unsigned s, d2, d;
    dx = longint'(p.ax) - longint'(p.bx);
    dy = longint'(p.ay) - longint'(p.by);
    s  = longint'(p.ra) + longint'(p.rb);
    d2 = dx*dx + dy*dy;
    r.px = '0;
    r.py = '0;
    r.co = 1'b0;
    r.ov = d2 < s*s;
    if (r.ov) begin
      d = isqrt(d2);
      if (d == 0) begin
        r.co = 1'b1;
      end else begin
        r.px = scale_comp(dx, s - d, d);
        r.py = scale_comp(dy, s - d, d);
      end
    end
    return r;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 90);
    return $urandom_range(1, 4);
  endfunction

  task automatic report(string what, logic [CW:0] got, logic [CW:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic add_pair(int ax, int ay, int bx, int by, int ra, int rb, bit drain = 0);
    pair_t p;
    p.ax = CW'(ax); p.ay = CW'(ay); p.bx = CW'(bx); p.by = CW'(by);
    p.ra = (CW-1)'(ra); p.rb = (CW-1)'(rb); p.drain = drain;
    pair_q.push_back(p);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        push_q.push_back(predict_push(cur_pair));
        in_count++;
        gap_in = calm_in ? 0 : pick_gap();
        if ($urandom_range(0, 59) == 0) calm_in = ~calm_in;
      end
      if (gap_in > 0) begin
        gap_in--;
        s_axis_tvalid <= 1'b0;
      end else if (pair_q.size() != 0 && (!pair_q[0].drain || push_q.size() == 0)) begin
        cur_pair = pair_q.pop_front();
        s_axis_tdata <= {2'b00, cur_pair.rb, cur_pair.ra, cur_pair.by, cur_pair.bx,
                         cur_pair.ay, cur_pair.ax};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    push_t w;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (push_q.size() == 0) begin
          report("unexpected transfer", m_axis_tdata[CW:0], '0);
        end else begin
          w = push_q.pop_front();
          if (m_axis_tdata[CW:0] !== w.px) report("push_x", m_axis_tdata[CW:0], w.px);
          if (m_axis_tdata[2*CW+1:CW+1] !== w.py)
            report("push_y", m_axis_tdata[2*CW+1:CW+1], w.py);
          if (m_axis_tuser[0] !== w.ov)
            report("overlap", (CW+1)'(m_axis_tuser[0]), (CW+1)'(w.ov));
          if (m_axis_tuser[1] !== w.co)
            report("coincident", (CW+1)'(m_axis_tuser[1]), (CW+1)'(w.co));
        end
      end
      if (!hold_done && in_count >= 150) begin
        hold_done = 1'b1;
        hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else if (gap_out > 0) begin
        gap_out--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        gap_out = calm_out ? 0 : pick_gap();
        if ($urandom_range(0, 49) == 0) calm_out = ~calm_out;
      end
    end
  end

  initial begin
    int unsigned s, ra, rb, bx, by, k;
    int dxo, dyo;
    // directed
    add_pair(0, 0, 0, 0, 0, 0);
    add_pair(0, 0, 0, 0, 1, 0);
    add_pair(100, -7, 100, -7, 8388607, 8388607);
    add_pair(8388607, 8388607, -8388608, -8388608, 8388607, 8388607);
    add_pair(-8388608, -8388608, 8388607, 8388607, 8388607, 8388607);
    add_pair(8388607, -8388608, -8388608, 8388607, 8388607, 8388607);
    add_pair(8388607, 0, -8388608, 0, 8388607, 8388607);
    add_pair(4096, 0, 0, 0, 2048, 2048);
    add_pair(4096, 0, 0, 0, 2049, 2048);
    add_pair(0, -4096, 0, 0, 4096, 1);
    add_pair(3, 4, 0, 0, 5, 1);
    add_pair(-3, -4, 0, 0, 6, 0);
    add_pair(1, 0, 0, 0, 1, 1);
    add_pair(0, 1, 0, 0, 0, 1);
    add_pair(-1, 1, 0, 0, 0, 2);
    add_pair(12345, -67890, 12000, -67000, 5000, 300);
    add_pair(-8388608, -8388608, -8388608, -8388608, 0, 0);
    add_pair(0, 0, 0, 0, 0, 8388607);
    add_pair(-8388608, 0, 8388607, 0, 1, 1);
    add_pair(200, 300, 0, 0, 4096, 4096, 1);
    // random
    for (int i = 0; i < 550; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        add_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 i == 300 || i == 450);
      end else begin
        k  = $urandom_range(0, 22);
        ra = $urandom & ((1 << (k + 1)) - 1);
        rb = $urandom & ((1 << $urandom_range(1, k + 1)) - 1);
        s  = ra + rb + 1;
        dxo = int'($urandom_range(0, 2*s)) - int'(s);
        dyo = int'($urandom_range(0, 2*s)) - int'(s);
        if ($urandom_range(0, 15) == 0) begin
          dxo = 0;
          dyo = 0;
        end
        bx = $urandom;
        by = $urandom;
        add_pair(bx + dxo, by + dyo, bx, by, ra, rb, i == 300 || i == 450);
      end
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pair_q.size() == 0 && !s_axis_tvalid);
    wait (push_q.size() == 0);
    repeat (LATENCY + 20) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: circle_penetration_vector_top.f
hdl/cpv_pkg.sv
hdl/cpv_front.sv
hdl/cpv_fifo.sv
hdl/cpv_back.sv
hdl/circle_penetration_vector_top.sv
dv/tb.sv
